// File: rtl/core/ffba_pkg.sv
// Shared types, codes and reset constants of the first-fit block allocator.
package ffba_pkg;

  localparam int unsigned DefMaxBlocks   = 64;
  localparam int unsigned DefHeaderBytes = 24;

  localparam logic [31:0] HeapBaseRst  = 32'd4096;
  localparam logic [31:0] HeapLimitRst = 32'd1048576;

  // Request kinds.
  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OOM     = 2'd1,
    STAT_ZERO    = 2'd2,
    STAT_UNKNOWN = 2'd3
  } status_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_HEAP_BASE  = 1'b0,
    CFG_HEAP_LIMIT = 1'b1
  } cfg_idx_e;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // One block table entry as it is kept in the table memory.
  typedef struct packed {
    logic [31:0] start;
    logic [23:0] bytes;
    logic        free;
  } entry_t;

  // One finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic [31:0] addr;
    status_e     status;
  } result_t;

endpackage

// File: rtl/core/ffba_ram.sv
// Generic single-write, single-read memory with a registered read port.
module ffba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/ffba_ctrl.sv
// Sequencer that scans the block table memory and updates it for one request.
module ffba_ctrl #(
  parameter int unsigned MaxBlocks   = ffba_pkg::DefMaxBlocks,
  parameter int unsigned HeaderBytes = ffba_pkg::DefHeaderBytes,
  localparam int unsigned IdxW       = $clog2(MaxBlocks),
  localparam int unsigned CntW       = $clog2(MaxBlocks + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_stall_o,
  input  logic                 kind_i,
  input  logic [23:0]          request_size_i,
  input  logic [31:0]          user_address_i,
  input  logic                 base_we_i,
  input  logic [31:0]          base_val_i,
  input  logic [31:0]          heap_limit_i,
  output logic                 res_valid_o,
  output ffba_pkg::result_t    res_o,
  input  logic                 res_take_i,
  output logic                 ram_we_o,
  output logic [IdxW-1:0]      ram_waddr_o,
  output ffba_pkg::entry_t     ram_wdata_o,
  output logic [IdxW-1:0]      ram_raddr_o,
  input  ffba_pkg::entry_t     ram_rdata_i
);
  import ffba_pkg::*;

  state_e         state_q, state_d;
  kind_e          kind_q, kind_d;
  logic [23:0]    size_q, size_d;
  logic [31:0]    addr_q, addr_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic           pend_q, pend_d;
  logic [IdxW-1:0] chk_idx_q, chk_idx_d;
  logic [CntW-1:0] blk_cnt_q, blk_cnt_d;
  logic [31:0]    brk_q, brk_d;
  logic [33:0]    end_q, end_d;
  result_t        res_q, res_d;

  logic           hit;
  logic           scan_over;
  logic [31:0]    chk_user;

  assign chk_user  = ram_rdata_i.start + 32'(HeaderBytes);
  assign scan_over = !pend_q && (scan_q >= blk_cnt_q);

  always_comb begin
    if (kind_q == KIND_ALLOC) begin
      hit = pend_q && ram_rdata_i.free && (ram_rdata_i.bytes >= size_q);
    end else begin
      hit = pend_q && (chk_user == addr_q);
    end
  end

  assign req_stall_o = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;
  assign ram_raddr_o = scan_q[IdxW-1:0];

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    size_d      = size_q;
    addr_d      = addr_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    chk_idx_d   = chk_idx_q;
    blk_cnt_d   = blk_cnt_q;
    brk_d       = brk_q;
    end_d       = end_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = chk_idx_q;
    ram_wdata_o = ram_rdata_i;

    if (base_we_i) begin
      brk_d = base_val_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          kind_d = kind_e'(kind_i);
          size_d = request_size_i;
          addr_d = user_address_i;
          scan_d = '0;
          pend_d = 1'b0;
          end_d  = {2'b00, brk_q} + 34'(HeaderBytes) + {10'd0, request_size_i};
          if (kind_e'(kind_i) == KIND_ALLOC && request_size_i == 24'd0) begin
            res_d   = '{addr: 32'd0, status: STAT_ZERO};
            state_d = ST_DONE;
          end else if (kind_e'(kind_i) == KIND_FREE && user_address_i == 32'd0) begin
            res_d   = '{addr: 32'd0, status: STAT_OK};
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          ram_we_o          = 1'b1;
          ram_waddr_o       = chk_idx_q;
          ram_wdata_o.free  = (kind_q == KIND_FREE);
          if (kind_q == KIND_ALLOC) begin
            res_d = '{addr: chk_user, status: STAT_OK};
          end else begin
            res_d = '{addr: 32'd0, status: STAT_OK};
          end
          state_d = ST_DONE;
        end else if (scan_over) begin
          state_d = ST_DONE;
          if (kind_q == KIND_FREE) begin
            res_d = '{addr: 32'd0, status: STAT_UNKNOWN};
          end else if (blk_cnt_q == CntW'(MaxBlocks) || end_q > {2'b00, heap_limit_i}) begin
            res_d = '{addr: 32'd0, status: STAT_OOM};
          end else begin
            // Append a new block at the break.
            ram_we_o    = 1'b1;
            ram_waddr_o = blk_cnt_q[IdxW-1:0];
            ram_wdata_o = '{start: brk_q, bytes: size_q, free: 1'b0};
            blk_cnt_d   = blk_cnt_q + CntW'(1);
            brk_d       = end_q[31:0];
            res_d       = '{addr: brk_q + 32'(HeaderBytes), status: STAT_OK};
          end
        end else begin
          // Issue the next table read; its data is checked next cycle.
          pend_d    = (scan_q < blk_cnt_q);
          chk_idx_d = scan_q[IdxW-1:0];
          if (scan_q < blk_cnt_q) begin
            scan_d = scan_q + CntW'(1);
          end
        end
      end
      ST_DONE: begin
        pend_d = 1'b0;
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pend_q    <= 1'b0;
      blk_cnt_q <= '0;
      brk_q     <= HeapBaseRst;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      blk_cnt_q <= blk_cnt_d;
      brk_q     <= brk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    size_q    <= size_d;
    addr_q    <= addr_d;
    scan_q    <= scan_d;
    chk_idx_q <= chk_idx_d;
    end_q     <= end_d;
    res_q     <= res_d;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_cnt_q <= CntW'(MaxBlocks))
    else $error("block count exceeds table depth");

  a_we_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> state_q == ST_SCAN)
    else $error("table written outside a scan");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |=> (blk_cnt_q == $past(blk_cnt_q)) ||
                 (blk_cnt_q == $past(blk_cnt_q) + CntW'(1)))
    else $error("block count moved by more than one");

  a_write_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |=> state_q == ST_DONE)
    else $error("table write did not finish the request");
`endif

endmodule

// File: rtl/core/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: configuration, table memory and output word.
//
// Usage: a request word enters on in_valid_i/in_stall_o with kind_i (allocate or
// free), request_size_i and user_address_i; it is accepted at a rising edge with
// in_valid_i high and in_stall_o low. Every request gives exactly one result word
// on out_valid_o/out_stall_i with granted_address_o and status_o.
// A zero-size allocate or a null free goes straight to the done state with its result
// registered, and passes on to the output register when that can take a word.
// Any other request scans the block table, one entry per cycle through the table
// memory's single read port, whose read data is registered. One request is worked
// on at a time: the next request is accepted only once the sequencer is idle again.
// The output register holds a finished word while the receiver stalls; the next
// request is accepted meanwhile, and its result waits in the sequencer until the
// output register empties.
// Reset clears the block count, loads the break pointer with the reset heap base
// and sets the heap limit to its reset value. The table memory needs no clearing:
// only entries below the block count are ever used. Configuration writes (heap_base
// also reloads the break) must be made by the user while idle, unchecked by the block.
module first_fit_block_allocator #(
  parameter int unsigned MaxBlocks   = ffba_pkg::DefMaxBlocks,
  parameter int unsigned HeaderBytes = ffba_pkg::DefHeaderBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [23:0] request_size_i,
  input  logic [31:0] user_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] granted_address_o,
  output logic [1:0]  status_o
);
  import ffba_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxBlocks);

  logic [31:0] heap_limit_q, heap_limit_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;

  logic        base_we;
  logic        res_valid;
  logic        res_take;
  result_t     res;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [IdxW-1:0] ram_raddr;
  entry_t          ram_wdata;
  entry_t          ram_rdata;

  // Configuration decode. A heap_base write only reloads the break pointer.
  assign base_we = cfg_we_i && (cfg_idx_e'(cfg_index_i) == CFG_HEAP_BASE);

  always_comb begin
    heap_limit_d = heap_limit_q;
    if (cfg_we_i && cfg_idx_e'(cfg_index_i) == CFG_HEAP_LIMIT) begin
      heap_limit_d = cfg_data_i;
    end
  end

  // The output register takes a new word when it is empty or being drained.
  assign res_take = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_take) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_limit_q <= HeapLimitRst;
      out_valid_q  <= 1'b0;
    end else begin
      heap_limit_q <= heap_limit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_q.addr;
  assign status_o          = out_q.status;

  ffba_ctrl #(
    .MaxBlocks   (MaxBlocks),
    .HeaderBytes (HeaderBytes)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (in_valid_i),
    .req_stall_o    (in_stall_o),
    .kind_i         (kind_i),
    .request_size_i (request_size_i),
    .user_address_i (user_address_i),
    .base_we_i      (base_we),
    .base_val_i     (cfg_data_i),
    .heap_limit_i   (heap_limit_q),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .res_take_i     (res_take),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

  // Block table: header address, payload size and free bit per entry.
  ffba_ram #(
    .Width ($bits(entry_t)),
    .Depth (MaxBlocks)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// File: dv/ffba_grant_check.sv
// Checker for the first-fit block allocator: predicts every result word and compares it.
module ffba_grant_check #(
  parameter int unsigned MaxBlocks   = ffba_pkg::DefMaxBlocks,
  parameter int unsigned HeaderBytes = ffba_pkg::DefHeaderBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        kind_i,
  input  logic [23:0] request_size_i,
  input  logic [31:0] user_address_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] granted_address_i,
  input  logic [1:0]  status_i,
  output int          pending_o,
  output int          errors_o
);
  import ffba_pkg::*;

  typedef struct {
    logic [31:0] addr;
    status_e     status;
  } grant_t;

  grant_t      expected_grants[$];
  logic [31:0] blk_start [MaxBlocks];
  logic [23:0] blk_bytes [MaxBlocks];
  logic        blk_free  [MaxBlocks];
  int unsigned blk_count;
  logic [31:0] heap_limit;
  logic [31:0] break_ptr;
  int          err_cnt = 0;

  assign errors_o = err_cnt;

  // Works out the result word of one request and updates the block table.
  task automatic predict_grant(input kind_e kind, input logic [23:0] size,
                               input logic [31:0] addr, output grant_t grant);
    logic [33:0] heap_end;
    bit          found;
    found        = 1'b0;
    grant.addr   = '0;
    grant.status = STAT_OK;
    if (kind == KIND_ALLOC) begin
      if (size == '0) begin
        grant.status = STAT_ZERO;
        return;
      end
      for (int i = 0; i < blk_count; i++) begin
        if (!found && blk_free[i] && blk_bytes[i] >= size) begin
          found       = 1'b1;
          blk_free[i] = 1'b0;
          grant.addr  = blk_start[i] + 32'(HeaderBytes);
        end
      end
      if (found) return;
      // The end of the new block is compared without wrap.
      heap_end = 34'(break_ptr) + 34'(HeaderBytes) + 34'(size);
      if (blk_count >= MaxBlocks || heap_end > 34'(heap_limit)) begin
        grant.status = STAT_OOM;
        return;
      end
      blk_start[blk_count] = break_ptr;
      blk_bytes[blk_count] = size;
      blk_free[blk_count]  = 1'b0;
      blk_count++;
      grant.addr = break_ptr + 32'(HeaderBytes);
      break_ptr  = heap_end[31:0];
    end else if (addr != '0) begin
      // With duplicate addresses the lowest entry is the one that is freed.
      for (int i = 0; i < blk_count; i++) begin
        if (!found && blk_start[i] + 32'(HeaderBytes) == addr) begin
          found       = 1'b1;
          blk_free[i] = 1'b1;
        end
      end
      if (!found) grant.status = STAT_UNKNOWN;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    grant_t got;
    if (!rst_ni) begin
      expected_grants.delete();
      blk_count  = 0;
      heap_limit = HeapLimitRst;
      break_ptr  = HeapBaseRst;
      foreach (blk_free[i]) blk_free[i] = 1'b0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_grants.size() == 0) begin
          err_cnt++;
          $display("%0t: result word with none expected: actual address %h status %0d",
                   $time, granted_address_i, status_i);
        end else begin
          want = expected_grants.pop_front();
          if (granted_address_i !== want.addr) begin
            err_cnt++;
            $display("%0t: granted address mismatch: expected %h, actual %h",
                     $time, want.addr, granted_address_i);
          end
          if (status_i !== want.status) begin
            err_cnt++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, status_i);
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_e'(cfg_index_i) == CFG_HEAP_BASE) begin
          break_ptr = cfg_data_i;
        end else begin
          heap_limit = cfg_data_i;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_grant(kind_e'(kind_i), request_size_i, user_address_i, got);
        expected_grants.push_back(got);
      end
      pending_o <= expected_grants.size();
    end
  end

endmodule

// File: dv/tb.sv
// Testbench top of the first-fit block allocator: clock, reset, request words and verdict.
module tb;
  import ffba_pkg::*;

  // User address offset of a block: its header size.
  localparam logic [31:0] HDR = 32'(DefHeaderBytes);
  // User addresses of the first two blocks appended after reset.
  localparam logic [31:0] FIRST_USER  = HeapBaseRst + HDR;
  localparam logic [31:0] SECOND_USER = HeapBaseRst + HDR + 32'd1 + HDR;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic        cfg_index_i    = 1'b0;
  logic [31:0] cfg_data_i     = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        kind_i         = 1'b0;
  logic [23:0] request_size_i = '0;
  logic [31:0] user_address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [31:0] granted_address_o;
  logic [1:0]  status_o;

  int pending;
  int errors;

  // Words left in the current burst of the sender; zero ends the burst and may start a gap.
  int burst_left = 0;
  // Set by the stimulus once to ask the receiver for its long hold-off.
  bit hold_wanted = 1'b0;
  bit hold_done   = 1'b0;
  // Addresses the block has handed out, used to aim free words at real blocks.
  logic [31:0] granted_pool[$];

  always #6 clk_i = ~clk_i;

  first_fit_block_allocator uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .request_size_i   (request_size_i),
    .user_address_i   (user_address_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .granted_address_o(granted_address_o),
    .status_o         (status_o)
  );

  ffba_grant_check grant_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .kind_i           (kind_i),
    .request_size_i   (request_size_i),
    .user_address_i   (user_address_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .granted_address_i(granted_address_o),
    .status_i         (status_o),
    .pending_o        (pending),
    .errors_o         (errors)
  );

  // The latest 128 successful grants are remembered so that later free words hit live,
  // freed and duplicated blocks rather than random addresses only.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i && status_o == STAT_OK &&
        granted_address_o != '0) begin
      granted_pool.push_back(granted_address_o);
      if (granted_pool.size() > 128) void'(granted_pool.pop_front());
    end
  end

  // Mostly small sizes so that freed blocks get reused, with zero sizes,
  // full-width random sizes and the largest size mixed in.
  function automatic logic [23:0] pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 10) return 24'($urandom);
    if (roll < 12) return '1;
    if (roll < 40) return 24'($urandom_range(256, 4096));
    return 24'($urandom_range(1, 255));
  endfunction

  // Free targets: mostly granted addresses (which also gives double frees),
  // some null words and some addresses that match no block.
  function automatic logic [31:0] pick_free_addr();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 25 || granted_pool.size() == 0) return $urandom;
    if (roll < 30) return granted_pool[$urandom_range(0, granted_pool.size() - 1)] + 32'd1;
    return granted_pool[$urandom_range(0, granted_pool.size() - 1)];
  endfunction

  // Offers one request word and returns at the edge where it is taken.
  // Bursts of random length are separated by random gaps; some bursts run
  // straight into the next one so that there are long stretches with no idle.
  task automatic send_word(input kind_e kind, input logic [23:0] size,
                           input logic [31:0] addr);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    request_size_i <= size;
    user_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic run_traffic(input int count, input int alloc_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < alloc_pct) begin
        send_word(KIND_ALLOC, pick_size(), $urandom);
      end else begin
        send_word(KIND_FREE, 24'($urandom), pick_free_addr());
      end
    end
  endtask

  // Stops offering and waits until every result word has come back, so the
  // block is idle and a register write is safe.
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: segments of random length, each with its own stall density,
  // from never stalling to stalling most cycles. Once asked, it holds off for
  // a long stretch so that the block fills up and stalls its input.
  initial begin
    int seg_len;
    int mode;
    wait (rst_ni);
    forever begin
      if (hold_wanted && !hold_done) begin
        hold_done = 1'b1;
        repeat (400) begin
          @(posedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(1, 40);
      repeat (seg_len) begin
        @(posedge clk_i);
        case (mode)
          0: begin
            out_stall_i <= 1'b0;
          end
          1: begin
            out_stall_i <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall_i <= $urandom_range(0, 1);
          end
          default: begin
            out_stall_i <= ($urandom_range(0, 3) != 0);
          end
        endcase
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [31:0] window_base;
    logic [32:0] window_end;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words with the reset configuration: zero size, the first two
    // appends, a size far beyond the heap limit, null and unknown frees,
    // a double free and reuse of freed blocks.
    send_word(KIND_ALLOC, 24'd0, '1);
    send_word(KIND_ALLOC, 24'd1, '0);
    send_word(KIND_ALLOC, 24'd100, '1);
    send_word(KIND_ALLOC, '1, '0);
    send_word(KIND_FREE, '1, '0);
    send_word(KIND_FREE, '0, '1);
    send_word(KIND_FREE, 24'd5, FIRST_USER);
    send_word(KIND_FREE, 24'd5, FIRST_USER);
    send_word(KIND_ALLOC, 24'd1, '0);
    send_word(KIND_FREE, '1, SECOND_USER);
    send_word(KIND_ALLOC, 24'd50, '1);
    send_word(KIND_ALLOC, 24'd200, '0);
    send_word(KIND_FREE, '0, 32'd1);
    send_word(KIND_FREE, '0, SECOND_USER);
    settle();

    // A zero heap limit: only reuse of freed blocks can succeed.
    write_reg(CFG_HEAP_LIMIT, '0);
    run_traffic(30, 60);
    settle();

    // Heap at address zero with the widest limit.
    write_reg(CFG_HEAP_BASE, '0);
    write_reg(CFG_HEAP_LIMIT, '1);
    run_traffic(60, 65);
    settle();

    // Back to the reset base: new blocks land on the addresses of the first
    // ones, so frees of those addresses must hit the lowest entry.
    write_reg(CFG_HEAP_BASE, HeapBaseRst);
    repeat (6) send_word(KIND_ALLOC, 24'($urandom_range(8192, 16384)), $urandom);
    send_word(KIND_FREE, '0, FIRST_USER);
    send_word(KIND_FREE, '0, FIRST_USER);
    send_word(KIND_ALLOC, 24'd1, '0);
    send_word(KIND_ALLOC, 24'd1, '0);
    run_traffic(32, 50);
    settle();

    // A random window of at most one megabyte anywhere in the address space.
    window_base = $urandom;
    window_end  = 33'(window_base) + 33'($urandom_range(0, 1 << 20));
    write_reg(CFG_HEAP_BASE, window_base);
    write_reg(CFG_HEAP_LIMIT, window_end[32] ? '1 : window_end[31:0]);
    run_traffic(100, 60);
    settle();

    // Break at the very top: every append runs out of memory.
    write_reg(CFG_HEAP_BASE, '1);
    write_reg(CFG_HEAP_LIMIT, '1);
    run_traffic(30, 70);
    settle();

    // Reset values again, with the receiver's long hold-off during traffic.
    write_reg(CFG_HEAP_BASE, HeapBaseRst);
    write_reg(CFG_HEAP_LIMIT, HeapLimitRst);
    hold_wanted = 1'b1;
    run_traffic(180, 50);
    settle();

    // Keep the clock running so that any stray result word would still be seen.
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
